// File: src/pidlev_pkg.sv
`timescale 1ns / 1ps

package pidlev_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TARGET_W = 9;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 11;
  localparam int ERR_W    = 11;   // target - sample lies in -1023..511
  localparam int ACC_W    = 12;   // integral, bounded by +/- 2047
  localparam int DERIV_W  = 12;
  localparam int PROD_PW  = GAIN_W + ERR_W;
  localparam int PROD_IW  = GAIN_W + ACC_W;
  localparam int PROD_DW  = GAIN_W + DERIV_W;
  localparam int SUM_W    = 30;
  localparam int QUOT_W   = SUM_W - 8;
  localparam int DUTY_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TARGET_W-1:0] TARGET_LOW   = 9'd100;
  localparam logic [TARGET_W-1:0] TARGET_HIGH  = 9'd300;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 9'd200;
  localparam logic [SAMPLE_W-1:0] CUTOFF_RESET = 10'd340;
  localparam logic [LIMIT_W-1:0]  WINDUP_RESET = 11'd2000;
  localparam logic [DUTY_W-1:0]   DUTY_MAX     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_GAIN_P = 3'd1,
    CFG_GAIN_I = 3'd2,
    CFG_GAIN_D = 3'd3,
    CFG_CUTOFF = 3'd4,
    CFG_WINDUP = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [TARGET_W-1:0]      target_level;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [SAMPLE_W-1:0]      cutoff_level;
    logic [LIMIT_W-1:0]       windup_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [ACC_W-1:0]   acc;
    logic signed [DERIV_W-1:0] deriv;
    logic                      cut;
  } err_stage_t;

  typedef struct packed {
    logic signed [PROD_PW-1:0] prod_p;
    logic signed [PROD_IW-1:0] prod_i;
    logic signed [PROD_DW-1:0] prod_d;
    logic                      cut;
  } prod_stage_t;

endpackage

// File: src/pidlev_err.sv
`timescale 1ns / 1ps

module pidlev_err (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic                                  item_i,
  input  logic [pidlev_pkg::SAMPLE_W-1:0]       sample_i,
  input  pidlev_pkg::cfg_t                      cfg_i,
  output pidlev_pkg::err_stage_t                stage_o
);

  logic signed [pidlev_pkg::ACC_W-1:0] error_sum_q, error_sum_d;
  logic signed [pidlev_pkg::ERR_W-1:0] last_error_q, last_error_d;
  pidlev_pkg::err_stage_t              stage_q, stage_d;

  logic signed [pidlev_pkg::ERR_W-1:0] err;
  logic signed [pidlev_pkg::ACC_W:0]   acc_raw;
  logic signed [pidlev_pkg::ACC_W:0]   lim_pos;
  logic signed [pidlev_pkg::ACC_W:0]   lim_neg;
  logic signed [pidlev_pkg::ACC_W-1:0] acc;

  always_comb begin
    err     = $signed({2'b00, cfg_i.target_level}) - $signed({1'b0, sample_i});
    acc_raw = $signed({error_sum_q[pidlev_pkg::ACC_W-1], error_sum_q})
            + $signed({{2{err[pidlev_pkg::ERR_W-1]}}, err});
    lim_pos = $signed({2'b00, cfg_i.windup_limit});
    lim_neg = -lim_pos;
    if (acc_raw > lim_pos) begin
      acc = lim_pos[pidlev_pkg::ACC_W-1:0];
    end else if (acc_raw < lim_neg) begin
      acc = lim_neg[pidlev_pkg::ACC_W-1:0];
    end else begin
      acc = acc_raw[pidlev_pkg::ACC_W-1:0];
    end

    stage_d.err   = err;
    stage_d.acc   = acc;
    stage_d.deriv = $signed({err[pidlev_pkg::ERR_W-1], err})
                  - $signed({last_error_q[pidlev_pkg::ERR_W-1], last_error_q});
    stage_d.cut   = (sample_i > cfg_i.cutoff_level);

    // integrator and history move only for a real item
    error_sum_d  = error_sum_q;
    last_error_d = last_error_q;
    if (load_i && item_i) begin
      error_sum_d  = acc;
      last_error_d = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else begin
      error_sum_q  <= error_sum_d;
      last_error_q <= last_error_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// File: src/pidlev_mult.sv
`timescale 1ns / 1ps

module pidlev_mult (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  pidlev_pkg::err_stage_t  stage_i,
  input  pidlev_pkg::cfg_t        cfg_i,
  output pidlev_pkg::prod_stage_t stage_o
);

  pidlev_pkg::prod_stage_t stage_q, stage_d;

  always_comb begin
    stage_d.prod_p = cfg_i.gain_p * stage_i.err;
    stage_d.prod_i = cfg_i.gain_i * stage_i.acc;
    stage_d.prod_d = cfg_i.gain_d * stage_i.deriv;
    stage_d.cut    = stage_i.cut;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// File: src/pidlev_out.sv
`timescale 1ns / 1ps

module pidlev_out (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  pidlev_pkg::prod_stage_t             stage_i,
  output logic [pidlev_pkg::DUTY_W-1:0]       duty_o,
  output logic                                cut_o
);

  localparam int SW = pidlev_pkg::SUM_W;
  localparam int QW = pidlev_pkg::QUOT_W;

  logic signed [SW-1:0]              sum;
  logic signed [SW-1:0]              biased;
  logic signed [QW-1:0]              quot;
  logic [QW-1:0]                     mag;
  logic [pidlev_pkg::DUTY_W-1:0]     duty_q, duty_d;
  logic                              cut_q;

  always_comb begin
    sum = $signed({{(SW-pidlev_pkg::PROD_PW){stage_i.prod_p[pidlev_pkg::PROD_PW-1]}},
                   stage_i.prod_p})
        + $signed({{(SW-pidlev_pkg::PROD_IW){stage_i.prod_i[pidlev_pkg::PROD_IW-1]}},
                   stage_i.prod_i})
        + $signed({{(SW-pidlev_pkg::PROD_DW){stage_i.prod_d[pidlev_pkg::PROD_DW-1]}},
                   stage_i.prod_d});
    // divide by 256 rounding toward zero
    biased = sum[SW-1] ? (sum + $signed(SW'(255))) : sum;
    quot   = biased[SW-1:8];
    mag    = -quot;
    if (!quot[QW-1] || stage_i.cut) begin
      duty_d = '0;
    end else if (mag[QW-1:8] != '0) begin
      duty_d = pidlev_pkg::DUTY_MAX;
    end else begin
      duty_d = mag[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      duty_q <= duty_d;
      cut_q  <= stage_i.cut;
    end
  end

  assign duty_o = duty_q;
  assign cut_o  = cut_q;

endmodule

// File: src/pid_levitation_controller.sv
`timescale 1ns / 1ps
// Each sample passes through the input register, then the error/integral,
// product and output stages.
// Throughput: one item per cycle; the pipeline only stops when the output stalls.
// Reset (rst_ni, async, active low) empties the pipeline, clears the integral
// and previous error, and loads the register defaults.
module pid_levitation_controller (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [pidlev_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pidlev_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                    sample_valid_i,
  output logic                                    sample_stall_o,
  input  logic [pidlev_pkg::SAMPLE_W-1:0]         sensor_sample_i,
  output logic                                    drive_valid_o,
  input  logic                                    drive_stall_i,
  output logic [pidlev_pkg::DUTY_W-1:0]           drive_duty_o,
  output logic                                    cut_off_o
);

  pidlev_pkg::cfg_t cfg_q, cfg_d;
  logic [pidlev_pkg::TARGET_W-1:0] target_wr;

  always_comb begin
    target_wr = cfg_data_i[pidlev_pkg::TARGET_W-1:0];
    if (target_wr < pidlev_pkg::TARGET_LOW) begin
      target_wr = pidlev_pkg::TARGET_LOW;
    end else if (target_wr > pidlev_pkg::TARGET_HIGH) begin
      target_wr = pidlev_pkg::TARGET_HIGH;
    end
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pidlev_pkg::CFG_TARGET: cfg_d.target_level = target_wr;
        pidlev_pkg::CFG_GAIN_P: cfg_d.gain_p = $signed(cfg_data_i);
        pidlev_pkg::CFG_GAIN_I: cfg_d.gain_i = $signed(cfg_data_i);
        pidlev_pkg::CFG_GAIN_D: cfg_d.gain_d = $signed(cfg_data_i);
        pidlev_pkg::CFG_CUTOFF:
          cfg_d.cutoff_level = cfg_data_i[pidlev_pkg::SAMPLE_W-1:0];
        pidlev_pkg::CFG_WINDUP:
          cfg_d.windup_limit = cfg_data_i[pidlev_pkg::LIMIT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_level <= pidlev_pkg::TARGET_RESET;
      cfg_q.gain_p       <= '0;
      cfg_q.gain_i       <= '0;
      cfg_q.gain_d       <= '0;
      cfg_q.cutoff_level <= pidlev_pkg::CUTOFF_RESET;
      cfg_q.windup_limit <= pidlev_pkg::WINDUP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control: a stage takes new data when empty or when it drains
  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  assign r4 = !v4_q || !drive_stall_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign sample_stall_o = !r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= sample_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  logic [pidlev_pkg::SAMPLE_W-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (r1) begin
      sample_q <= sensor_sample_i;
    end
  end

  pidlev_pkg::err_stage_t  err_stage;
  pidlev_pkg::prod_stage_t prod_stage;

  pidlev_err u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (r2),
    .item_i   (v1_q),
    .sample_i (sample_q),
    .cfg_i    (cfg_q),
    .stage_o  (err_stage)
  );

  pidlev_mult u_mult (
    .clk_i   (clk_i),
    .load_i  (r3),
    .stage_i (err_stage),
    .cfg_i   (cfg_q),
    .stage_o (prod_stage)
  );

  pidlev_out u_out (
    .clk_i   (clk_i),
    .load_i  (r4),
    .stage_i (prod_stage),
    .duty_o  (drive_duty_o),
    .cut_o   (cut_off_o)
  );

  assign drive_valid_o = v4_q;

`ifndef SYNTHESIS
  a_cut_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_valid_o && cut_off_o |-> drive_duty_o == '0)
    else $error("drive nonzero while cut off");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_stall_o |-> drive_valid_o && drive_stall_i && v1_q && v2_q && v3_q)
    else $error("input stalled with room in the pipeline");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drive_stall_i |-> !sample_stall_o)
    else $error("input stalled while output flows");

  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && !sample_stall_o && !drive_stall_i |=> v1_q)
    else $error("accepted item lost at input register");
`endif

endmodule
